// ===== rtl/tlqp_pkg.sv =====
// Shared types and constants for the two-level queue with promotion.
// Used by tlqp_cell, tlqp_row and two_level_queue_with_promote; no dependencies.
package tlqp_pkg;

    localparam int ID_W          = 14;
    localparam int TAG_W         = 16;
    localparam int OP_W          = 2;
    localparam int STATUS_W      = 4;
    localparam int DATA_W        = 32;
    localparam int QUEUE_DEPTH_DEF = 16;

    // Operation codes carried on s_tuser
    typedef enum logic [OP_W-1:0] {
        OP_REQUEST = 2'd0,
        OP_GRANT   = 2'd1,
        OP_PROMOTE = 2'd2,
        OP_DRAIN   = 2'd3
    } op_t;

    // Result status codes carried on m_tuser
    typedef enum logic [STATUS_W-1:0] {
        STAT_ACCEPTED    = 4'd0,
        STAT_FULL        = 4'd1,
        STAT_GRANT_URG   = 4'd2,
        STAT_GRANT_NORM  = 4'd3,
        STAT_NONE        = 4'd4,
        STAT_PROMOTED    = 4'd5,
        STAT_NOT_FOUND   = 4'd6,
        STAT_DRAIN_URG   = 4'd7,
        STAT_DRAIN_NORM  = 4'd8,
        STAT_DRAIN_EMPTY = 4'd9
    } status_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_EXEC  = 2'd1,
        ST_DRAIN = 2'd2
    } state_t;

    // One queue entry
    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [ID_W-1:0]  id;
    } entry_t;

    // Command from the controller to one queue row
    typedef struct packed {
        logic append;
        logic pop;
        logic remove;
    } row_cmd_t;

    // Per-cell control from the row
    typedef struct packed {
        logic occupied;
        logic load;
        logic pop;
        logic remove;
    } cell_ctl_t;

endpackage

// ===== rtl/tlqp_cell.sv =====
// One storage cell of a queue row: holds an entry, compares it to the key
// and takes its neighbor's entry when the row closes a gap. Uses tlqp_pkg.
module tlqp_cell (
    input  logic                       aclk,
    input  tlqp_pkg::cell_ctl_t        ctl,
    input  logic [tlqp_pkg::ID_W-1:0]  key,
    input  tlqp_pkg::entry_t           new_entry,
    input  tlqp_pkg::entry_t           nbr_entry,
    input  logic                       found_in,
    output tlqp_pkg::entry_t           entry,
    output logic                       found_out,
    output logic                       first_hit
);
    import tlqp_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   hit;

    // Compare the held id against the key; pass the match chain on
    assign hit       = ctl.occupied && (entry_reg.id == key);
    assign found_out = found_in || hit;
    assign first_hit = hit && !found_in;

    // Load a new entry, take the neighbor's entry, or hold
    always_comb begin
        entry_next = entry_reg;
        if (ctl.load) begin
            entry_next = new_entry;
        end else if (ctl.pop || (ctl.remove && found_out)) begin
            entry_next = nbr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== rtl/tlqp_row.sv =====
// One FIFO built as a row of tlqp_cell instances plus its fill count;
// supports append, pop of the head and removal of the first key match.
// Uses tlqp_pkg and tlqp_cell.
module tlqp_row #(
    parameter int DEPTH = tlqp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  tlqp_pkg::row_cmd_t         cmd,
    input  logic [tlqp_pkg::ID_W-1:0]  key,
    input  tlqp_pkg::entry_t           new_entry,
    output tlqp_pkg::entry_t           head,
    output logic [$clog2(DEPTH+1)-1:0] count,
    output logic                       empty,
    output logic                       full,
    output logic                       found,
    output logic [tlqp_pkg::TAG_W-1:0] match_tag
);
    import tlqp_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    entry_t           entries [DEPTH];
    entry_t           nbr     [DEPTH];
    logic [DEPTH:0]   found_chain;
    logic [DEPTH-1:0] first_hit;
    cell_ctl_t        ctl     [DEPTH];

    assign found_chain[0] = 1'b0;

    // Build the row; the tail cell takes nothing from beyond the end
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        if (i == DEPTH - 1) begin : g_tail
            assign nbr[i] = '0;
        end else begin : g_body
            assign nbr[i] = entries[i+1];
        end

        assign ctl[i].occupied = CNT_W'(i) < count_reg;
        assign ctl[i].load     = cmd.append && !full && (count_reg == CNT_W'(i));
        assign ctl[i].pop      = cmd.pop;
        assign ctl[i].remove   = cmd.remove;

        tlqp_cell u_cell (
            .aclk      (aclk),
            .ctl       (ctl[i]),
            .key       (key),
            .new_entry (new_entry),
            .nbr_entry (nbr[i]),
            .found_in  (found_chain[i]),
            .entry     (entries[i]),
            .found_out (found_chain[i+1]),
            .first_hit (first_hit[i])
        );
    end

    // Select the tag of the first matching cell
    always_comb begin
        match_tag = '0;
        for (int i = 0; i < DEPTH; i++) begin
            match_tag = match_tag | (entries[i].tag & {TAG_W{first_hit[i]}});
        end
    end

    assign found = found_chain[DEPTH];
    assign head  = entries[0];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign count = count_reg;

    // Advance the fill count
    always_comb begin
        count_next = count_reg;
        if (cmd.append && !full) begin
            count_next = count_reg + 1'b1;
        end else if ((cmd.pop && !empty) || (cmd.remove && found)) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/two_level_queue_with_promote.sv =====
// Top level of the two-level queue with promotion: controller, two cell rows
// and the result register. Uses tlqp_pkg and tlqp_row.
//
//  channel  ports                    payload
//  input    s_tvalid/s_tready        s_tuser: op; s_tdata: flight_id, origin_tag
//  result   m_tvalid/m_tready        m_tuser: status; m_tdata: out_flight,
//                                    out_origin; m_tlast: last
//
// An item is transferred in, then executed: the rows compare, shift and
// append in parallel across all cells.
// A drain returns one result per cycle, one for each entry held, while the
// result register is free; each result comes from the head of a row.
// The result register lets the next item transfer in while a result waits;
// an item waits in execution only until that register is free.
// aresetn (synchronous) empties both queues; no clearing pass is needed.
module two_level_queue_with_promote #(
    parameter int QUEUE_DEPTH = tlqp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [13:0] flight_id, [29:14] origin_tag, [31:30] zero
    input  logic [tlqp_pkg::DATA_W-1:0]    s_tdata,
    // [1:0] op
    input  logic [tlqp_pkg::OP_W-1:0]      s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [13:0] out_flight, [29:14] out_origin, [31:30] zero
    output logic [tlqp_pkg::DATA_W-1:0]    m_tdata,
    // [3:0] status
    output logic [tlqp_pkg::STATUS_W-1:0]  m_tuser,
    output logic                           m_tlast
);
    import tlqp_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    state_t            state_reg;
    state_t            state_next;
    op_t               op_reg;
    logic [ID_W-1:0]   id_reg;
    logic [TAG_W-1:0]  tag_reg;

    logic              m_valid_reg;
    status_t           status_reg;
    logic [ID_W-1:0]   flight_reg;
    logic [TAG_W-1:0]  origin_reg;
    logic              last_reg;

    logic              out_free;
    logic              out_load;
    status_t           out_status;
    logic [ID_W-1:0]   out_flight;
    logic [TAG_W-1:0]  out_origin;
    logic              out_last;

    row_cmd_t          u_cmd;
    row_cmd_t          n_cmd;
    entry_t            u_new;
    entry_t            n_new;
    entry_t            u_head;
    entry_t            n_head;
    logic [CNT_W-1:0]  u_count;
    logic [CNT_W-1:0]  n_count;
    logic              u_empty;
    logic              u_full;
    logic              n_empty;
    logic              n_full;
    logic              n_found;
    logic [TAG_W-1:0]  n_match_tag;
    logic [CNT_W:0]    total;
    logic              drain_last;

    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_tready;

    // Capture the accepted item
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg  <= op_t'(s_tuser);
            id_reg  <= s_tdata[ID_W-1:0];
            tag_reg <= s_tdata[ID_W+TAG_W-1:ID_W];
        end
    end

    assign n_new      = '{tag: tag_reg, id: id_reg};
    assign u_new      = '{tag: n_match_tag, id: id_reg};
    assign total      = {1'b0, u_count} + {1'b0, n_count};
    assign drain_last = (total == (CNT_W+1)'(1));

    tlqp_row #(.DEPTH(QUEUE_DEPTH)) u_urgent (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (u_cmd),
        .key       (id_reg),
        .new_entry (u_new),
        .head      (u_head),
        .count     (u_count),
        .empty     (u_empty),
        .full      (u_full),
        .found     (),
        .match_tag ()
    );

    tlqp_row #(.DEPTH(QUEUE_DEPTH)) u_normal (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (n_cmd),
        .key       (id_reg),
        .new_entry (n_new),
        .head      (n_head),
        .count     (n_count),
        .empty     (n_empty),
        .full      (n_full),
        .found     (n_found),
        .match_tag (n_match_tag)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    if (op_reg == OP_DRAIN && !(u_empty && n_empty)) begin
                        state_next = ST_DRAIN;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DRAIN: begin
                if (out_free && drain_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Row commands and result fields
    always_comb begin
        out_load   = 1'b0;
        out_status = STAT_ACCEPTED;
        out_flight = '0;
        out_origin = '0;
        out_last   = 1'b1;
        u_cmd      = '0;
        n_cmd      = '0;
        case (state_reg)
            ST_EXEC: begin
                if (out_free) begin
                    out_load = 1'b1;
                    case (op_reg)
                        OP_REQUEST: begin
                            if (n_full) begin
                                out_status = STAT_FULL;
                            end else begin
                                n_cmd.append = 1'b1;
                            end
                        end
                        OP_GRANT: begin
                            if (!u_empty) begin
                                out_status = STAT_GRANT_URG;
                                out_flight = u_head.id;
                                out_origin = u_head.tag;
                                u_cmd.pop  = 1'b1;
                            end else if (!n_empty) begin
                                out_status = STAT_GRANT_NORM;
                                out_flight = n_head.id;
                                out_origin = n_head.tag;
                                n_cmd.pop  = 1'b1;
                            end else begin
                                out_status = STAT_NONE;
                            end
                        end
                        OP_PROMOTE: begin
                            if (!n_found) begin
                                out_status = STAT_NOT_FOUND;
                            end else if (u_full) begin
                                out_status = STAT_FULL;
                            end else begin
                                out_status   = STAT_PROMOTED;
                                n_cmd.remove = 1'b1;
                                u_cmd.append = 1'b1;
                            end
                        end
                        OP_DRAIN: begin
                            if (u_empty && n_empty) begin
                                out_status = STAT_DRAIN_EMPTY;
                            end else begin
                                out_load = 1'b0;
                            end
                        end
                        default: out_load = 1'b0;
                    endcase
                end
            end
            ST_DRAIN: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_last = drain_last;
                    if (!u_empty) begin
                        out_status = STAT_DRAIN_URG;
                        out_flight = u_head.id;
                        out_origin = u_head.tag;
                        u_cmd.pop  = 1'b1;
                    end else begin
                        out_status = STAT_DRAIN_NORM;
                        out_flight = n_head.id;
                        out_origin = n_head.tag;
                        n_cmd.pop  = 1'b1;
                    end
                end
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Result register: load a new result, or drop the one just transferred
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            status_reg <= out_status;
            flight_reg <= out_flight;
            origin_reg <= out_origin;
            last_reg   <= out_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {{(DATA_W-ID_W-TAG_W){1'b0}}, origin_reg, flight_reg};
    assign m_tlast  = last_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (u_count <= CNT_W'(QUEUE_DEPTH)) && (n_count <= CNT_W'(QUEUE_DEPTH)))
        else $error("queue fill count beyond depth");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item taken while one is in execution");

    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == STAT_DRAIN_EMPTY) |-> m_tlast)
        else $error("empty drain result without last");

    a_drain_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast &&
         (m_tuser == STAT_DRAIN_URG || m_tuser == STAT_DRAIN_NORM))
        |-> (u_count == '0 && n_count == '0))
        else $error("queues not empty after final drain transfer");
`endif

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for two_level_queue_with_promote: directed table, then random traffic.
// A queue model predicts every result and random gaps stall both stream channels.
// Depends on rtl/tlqp_pkg.sv and rtl/two_level_queue_with_promote.sv.
module tb_top;
    import tlqp_pkg::*;

    localparam int DEPTH         = QUEUE_DEPTH_DEF;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RAND_PHASES   = 5;
    localparam int PHASE_ITEMS   = 37;
    localparam int DIR_ROWS      = 22;

    typedef struct packed {
        status_t          status;
        logic [ID_W-1:0]  flight;
        logic [TAG_W-1:0] origin;
        logic             last;
    } result_t;

    // One directed row; typed rows carry a single result with zero payload
    typedef struct {
        op_t              op;
        logic [ID_W-1:0]  id;
        logic [TAG_W-1:0] tag;
        int               reps;
        bit               typed;
        status_t          status;
    } stim_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [DATA_W-1:0]    s_tdata;
    logic [OP_W-1:0]      s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [DATA_W-1:0]    m_tdata;
    logic [STATUS_W-1:0]  m_tuser;
    logic                 m_tlast;

    // Model state and pending results
    entry_t  normal_q[$];
    entry_t  urgent_q[$];
    result_t pending_results[$];
    result_t item_results[$];
    int      error_count = 0;
    int      idle_cycles = 0;
    int      ready_hold  = 0;
    bit      no_idle     = 1'b0;

    stim_row_t directed_rows [0:DIR_ROWS-1] = '{
        '{OP_GRANT,   14'h0000, 16'h0000,  1, 1'b1, STAT_NONE},
        '{OP_DRAIN,   14'h0000, 16'h0000,  1, 1'b1, STAT_DRAIN_EMPTY},
        '{OP_PROMOTE, 14'h0000, 16'h0000,  1, 1'b1, STAT_NOT_FOUND},
        '{OP_REQUEST, 14'h0000, 16'h0000,  1, 1'b1, STAT_ACCEPTED},
        '{OP_REQUEST, 14'h3FFF, 16'hFFFF,  1, 1'b1, STAT_ACCEPTED},
        '{OP_REQUEST, 14'd9999, 16'hA5A5,  1, 1'b1, STAT_ACCEPTED},
        '{OP_PROMOTE, 14'h3FFF, 16'h0000,  1, 1'b1, STAT_PROMOTED},
        '{OP_PROMOTE, 14'd1234, 16'hFFFF,  1, 1'b1, STAT_NOT_FOUND},
        '{OP_GRANT,   14'h3FFF, 16'hFFFF,  1, 1'b0, STAT_NONE},
        '{OP_GRANT,   14'h0000, 16'h0000,  1, 1'b0, STAT_NONE},
        '{OP_REQUEST, 14'd9999, 16'h1234,  1, 1'b1, STAT_ACCEPTED},
        '{OP_PROMOTE, 14'd9999, 16'h0000,  1, 1'b1, STAT_PROMOTED},
        '{OP_DRAIN,   14'h0000, 16'h0000,  1, 1'b0, STAT_NONE},
        '{OP_REQUEST, 14'h2AAA, 16'h5555, 16, 1'b1, STAT_ACCEPTED},
        '{OP_REQUEST, 14'h1555, 16'hAAAA,  1, 1'b1, STAT_FULL},
        '{OP_PROMOTE, 14'h2AAA, 16'h0000, 16, 1'b1, STAT_PROMOTED},
        '{OP_REQUEST, 14'h1555, 16'hAAAA,  1, 1'b1, STAT_ACCEPTED},
        '{OP_PROMOTE, 14'h1555, 16'h0000,  1, 1'b1, STAT_FULL},
        '{OP_REQUEST, 14'h2AAA, 16'hFFFF, 15, 1'b1, STAT_ACCEPTED},
        '{OP_REQUEST, 14'h0000, 16'h0000,  1, 1'b1, STAT_FULL},
        '{OP_DRAIN,   14'h0000, 16'h0000,  1, 1'b0, STAT_NONE},
        '{OP_GRANT,   14'h0000, 16'h0000,  1, 1'b1, STAT_NONE}
    };

    two_level_queue_with_promote #(
        .QUEUE_DEPTH(DEPTH)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    // Free-running clock, period 12
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    function automatic result_t make_result(status_t st, entry_t e, logic is_last);
        result_t r;
        r.status = st;
        r.flight = e.id;
        r.origin = e.tag;
        r.last   = is_last;
        return r;
    endfunction

    // Apply one operation to the queue model and collect the results it causes
    function automatic void predict_queue_op(op_t op, logic [ID_W-1:0] item_id,
                                             logic [TAG_W-1:0] item_tag);
        entry_t blank;
        entry_t fresh;
        int     pos;
        int     total;
        int     k;
        blank = '0;
        item_results.delete();
        case (op)
            OP_REQUEST: begin
                if (normal_q.size() >= DEPTH) begin
                    item_results.push_back(make_result(STAT_FULL, blank, 1'b1));
                end else begin
                    fresh.id  = item_id;
                    fresh.tag = item_tag;
                    normal_q.push_back(fresh);
                    item_results.push_back(make_result(STAT_ACCEPTED, blank, 1'b1));
                end
            end
            OP_GRANT: begin
                if (urgent_q.size() > 0) begin
                    item_results.push_back(make_result(STAT_GRANT_URG, urgent_q[0], 1'b1));
                    urgent_q.delete(0);
                end else if (normal_q.size() > 0) begin
                    item_results.push_back(make_result(STAT_GRANT_NORM, normal_q[0], 1'b1));
                    normal_q.delete(0);
                end else begin
                    item_results.push_back(make_result(STAT_NONE, blank, 1'b1));
                end
            end
            OP_PROMOTE: begin
                // First match wins; later entries close the gap
                pos = -1;
                for (int i = 0; i < normal_q.size(); i++) begin
                    if (pos < 0 && normal_q[i].id == item_id) begin
                        pos = i;
                    end
                end
                if (pos < 0) begin
                    item_results.push_back(make_result(STAT_NOT_FOUND, blank, 1'b1));
                end else if (urgent_q.size() >= DEPTH) begin
                    item_results.push_back(make_result(STAT_FULL, blank, 1'b1));
                end else begin
                    urgent_q.push_back(normal_q[pos]);
                    normal_q.delete(pos);
                    item_results.push_back(make_result(STAT_PROMOTED, blank, 1'b1));
                end
            end
            default: begin
                // Drain urgent first, then normal, last flag on the final one
                total = urgent_q.size() + normal_q.size();
                k = 0;
                if (total == 0) begin
                    item_results.push_back(make_result(STAT_DRAIN_EMPTY, blank, 1'b1));
                end
                foreach (urgent_q[i]) begin
                    item_results.push_back(make_result(STAT_DRAIN_URG, urgent_q[i],
                                                       k == total - 1));
                    k++;
                end
                foreach (normal_q[i]) begin
                    item_results.push_back(make_result(STAT_DRAIN_NORM, normal_q[i],
                                                       k == total - 1));
                    k++;
                end
                urgent_q.delete();
                normal_q.delete();
            end
        endcase
    endfunction

    // Half back-to-back, most others short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Ids cluster around the four-digit limit so duplicates and out-of-range keys occur
    function automatic logic [ID_W-1:0] pick_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return ID_W'($urandom_range(9990, 10009));
        end else if (r < 80) begin
            return ID_W'($urandom_range(0, 9999));
        end
        return ID_W'($urandom_range(0, (1 << ID_W) - 1));
    endfunction

    // Drive one item, hold it until the transfer, then queue its expected results
    task automatic send_item(op_t op, logic [ID_W-1:0] item_id, logic [TAG_W-1:0] item_tag,
                             bit typed, status_t typed_status);
        int     gap;
        entry_t blank;
        blank = '0;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(DATA_W - ID_W - TAG_W){1'b0}}, item_tag, item_id};
        do @(posedge aclk); while (!s_tready);
        predict_queue_op(op, item_id, item_tag);
        if (typed) begin
            pending_results.push_back(make_result(typed_status, blank, 1'b1));
        end else begin
            foreach (item_results[i]) begin
                pending_results.push_back(item_results[i]);
            end
        end
    endtask

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Result side backpressure: ready bursts, short stalls, occasional long stalls
    always @(posedge aclk) begin
        if (no_idle) begin
            m_tready <= 1'b1;
            ready_hold = 0;
        end else if (ready_hold > 0) begin
            ready_hold = ready_hold - 1;
        end else if ($urandom_range(0, 1) == 0) begin
            m_tready <= 1'b1;
            ready_hold = $urandom_range(0, 12);
        end else begin
            m_tready <= 1'b0;
            ready_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                     : $urandom_range(0, 2);
        end
    end

    // Compare each result transfer with the oldest pending expectation
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result status %0d flight %0d origin %0d last %0b",
                         $time, m_tuser, m_tdata[ID_W-1:0], m_tdata[ID_W+TAG_W-1:ID_W],
                         m_tlast);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", want.status, m_tuser);
                check_field("out_flight", want.flight, m_tdata[ID_W-1:0]);
                check_field("out_origin", want.origin, m_tdata[ID_W+TAG_W-1:ID_W]);
                check_field("last", want.last, m_tlast);
            end
        end
    end

    // Abort when no transfer happens on either channel for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int               phase;
        int               n;
        int               pick;
        bit               fill_heavy;
        op_t              op;
        logic [ID_W-1:0]  item_id;
        logic [TAG_W-1:0] item_tag;

        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_REQUEST;
        m_tready <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table: empty cases, extreme fields, both full cases, largest drain
        foreach (directed_rows[r]) begin
            repeat (directed_rows[r].reps) begin
                send_item(directed_rows[r].op, directed_rows[r].id, directed_rows[r].tag,
                          directed_rows[r].typed, directed_rows[r].status);
            end
        end

        // Random phases: first without idling, fill-heavy mixes drive the queues toward full
        for (phase = 0; phase < RAND_PHASES; phase++) begin
            no_idle = (phase == 0);
            fill_heavy = (phase == 1 || phase == 4);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < (fill_heavy ? 70 : 40)) begin
                    op = OP_REQUEST;
                end else if (pick < (fill_heavy ? 75 : 65)) begin
                    op = OP_GRANT;
                end else if (pick < (fill_heavy ? 97 : 90)) begin
                    op = OP_PROMOTE;
                end else begin
                    op = OP_DRAIN;
                end
                item_tag = TAG_W'($urandom_range(0, (1 << TAG_W) - 1));
                item_id  = pick_id();
                // Promotes mostly name an id that is waiting in the normal queue
                if (op == OP_PROMOTE) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 70 && normal_q.size() > 0) begin
                        item_id = normal_q[$urandom_range(0, normal_q.size() - 1)].id;
                    end else if (pick < 85 && urgent_q.size() > 0) begin
                        item_id = urgent_q[$urandom_range(0, urgent_q.size() - 1)].id;
                    end
                end
                send_item(op, item_id, item_tag, 1'b0, STAT_NONE);
            end
        end
        no_idle = 1'b0;
        s_tvalid <= 1'b0;

        // Let every pending result arrive, then watch for strays
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== two_level_queue_with_promote.f =====
rtl/tlqp_pkg.sv
rtl/tlqp_cell.sv
rtl/tlqp_row.sv
rtl/two_level_queue_with_promote.sv
sim/tb_top.sv
